// ===== hw/rtl/interpolated_rate_table_unit_macros.svh =====
// Assertion helpers for the rate table pipeline.
`ifndef INTERPOLATED_RATE_TABLE_UNIT_MACROS_SVH
`define INTERPOLATED_RATE_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define IRT_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("rate table assertion failed");
// Implication after a fixed number of cycles.
`define IRT_ASSERT_DELAY(lbl, ck, rn, ante, n, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> ##n (cons)) \
    else $error("rate table assertion failed");
`else
`define IRT_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define IRT_ASSERT_DELAY(lbl, ck, rn, ante, n, cons)
`endif
`endif

// ===== hw/rtl/irt_pkg.sv =====
`timescale 1ns / 1ps
package irt_pkg;

  localparam int NUM_SPECIES_DEF = 4;
  localparam int NUM_POINTS_DEF  = 1024;

  localparam int RATE_W = 32;
  localparam int PAIR_W = 2;
  localparam int FRAC_W = 16;
  localparam int SPEC_W = 2;
  localparam int GRID_W = 10;
  localparam int NDIV_W = 10;
  localparam int CFG_W  = 32;
  localparam int CIDX_W = 2;

  // Accept edge to result edge.
  localparam int LATENCY = 7;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_X_MIN    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_INV_STEP = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_NUM_DIV  = 2'd2;

  localparam logic [RATE_W-1:0] X_MIN_RST    = 32'h0000_0000;
  localparam logic [RATE_W-1:0] INV_STEP_RST = 32'h0001_0000;
  localparam logic [NDIV_W-1:0] NUM_DIV_RST  = 10'd1023;

  // Control that travels beside each transaction.
  typedef struct packed {
    logic vld;
    logic lookup;
    logic spec_ok;
    logic wr_ok;
    logic oor;
  } irt_ctl_t;

endpackage

// ===== hw/rtl/irt_index.sv =====
`timescale 1ns / 1ps
module irt_index #(
  parameter int NUM_SPECIES = irt_pkg::NUM_SPECIES_DEF,
  parameter int NUM_POINTS  = irt_pkg::NUM_POINTS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        acc,
  input  logic                                        op,
  input  logic [irt_pkg::SPEC_W-1:0]                  species,
  input  logic [irt_pkg::GRID_W-1:0]                  grid_index,
  input  logic [irt_pkg::RATE_W-1:0]                  load_first,
  input  logic [irt_pkg::RATE_W-1:0]                  load_second,
  input  logic [irt_pkg::RATE_W-1:0]                  x_value,
  input  logic [irt_pkg::RATE_W-1:0]                  x_min,
  input  logic [irt_pkg::RATE_W-1:0]                  inv_step,
  input  logic [irt_pkg::NDIV_W-1:0]                  num_div,
  output irt_pkg::irt_ctl_t                           ctl_o,
  output logic [irt_pkg::SPEC_W-1:0]                  species_o,
  output logic [$clog2(NUM_POINTS)-1:0]               lo_idx_o,
  output logic [$clog2(NUM_POINTS)-1:0]               hi_idx_o,
  output logic [irt_pkg::FRAC_W-1:0]                  frac_o,
  output logic [irt_pkg::PAIR_W*irt_pkg::RATE_W-1:0]  wr_pair_o
);
  import irt_pkg::*;

  localparam int IW = $clog2(NUM_POINTS);
  localparam int PW = PAIR_W * RATE_W;

  // Stage 1: offset from grid origin
  irt_ctl_t           ctl1_r, ctl1_nxt;
  logic [SPEC_W-1:0]  spec1_r;
  logic [GRID_W-1:0]  grid1_r;
  logic [PW-1:0]      ld1_r;
  logic [RATE_W:0]    d1_r, d1_nxt;

  // Stage 2: scale by inverse spacing
  irt_ctl_t           ctl2_r;
  logic [SPEC_W-1:0]  spec2_r;
  logic [GRID_W-1:0]  grid2_r;
  logic [PW-1:0]      ld2_r;
  logic               neg2_r;
  logic [47:0]        ph2_r, ph2_nxt;
  logic [31:0]        pl2_r, pl2_nxt;
  logic [47:0]        pl_full;

  // Stage 3: locate interval and clamp
  irt_ctl_t           ctl3_r, ctl3_nxt;
  logic [SPEC_W-1:0]  spec3_r;
  logic [IW-1:0]      lo3_r, lo3_nxt;
  logic [IW-1:0]      hi3_r, hi3_nxt;
  logic [FRAC_W-1:0]  frac3_r, frac3_nxt;
  logic [PW-1:0]      ld3_r;

  logic [48:0]        q;
  logic [32:0]        whole;
  logic [FRAC_W-1:0]  q_frac;
  logic [31:0]        nd_full;
  logic [IW-1:0]      nd;

  always_comb begin
    ctl1_nxt.vld     = acc;
    ctl1_nxt.lookup  = (op == OP_LOOKUP);
    ctl1_nxt.spec_ok = (32'(species) < NUM_SPECIES);
    ctl1_nxt.wr_ok   = (32'(species) < NUM_SPECIES) && (32'(grid_index) < NUM_POINTS);
    ctl1_nxt.oor     = 1'b0;
    d1_nxt = {x_value[RATE_W-1], x_value} - {x_min[RATE_W-1], x_min};
  end

  always_comb begin
    ph2_nxt = 48'(d1_r[31:16]) * 48'(inv_step);
    pl_full = 48'(d1_r[15:0]) * 48'(inv_step);
    pl2_nxt = pl_full[47:16];
  end

  always_comb begin
    if (num_div == '0) begin
      nd_full = 32'd1;
    end else if (32'(num_div) > 32'(NUM_POINTS - 1)) begin
      nd_full = 32'(NUM_POINTS - 1);
    end else begin
      nd_full = 32'(num_div);
    end
    nd     = IW'(nd_full);
    q      = {1'b0, ph2_r} + 49'(pl2_r);
    whole  = q[48:16];
    q_frac = q[15:0];

    ctl3_nxt  = ctl2_r;
    lo3_nxt   = '0;
    hi3_nxt   = '0;
    frac3_nxt = '0;
    if (!ctl2_r.lookup) begin
      lo3_nxt = IW'(grid2_r);
      hi3_nxt = IW'(grid2_r);
    end else if (!ctl2_r.spec_ok) begin
      ctl3_nxt.oor = 1'b1;
    end else if (neg2_r) begin
      ctl3_nxt.oor = 1'b1;
    end else if (whole >= 33'(nd)) begin
      // clamp to last point; exact hit on it is still in range
      ctl3_nxt.oor = (whole != 33'(nd)) || (q_frac != '0);
      lo3_nxt      = nd;
      hi3_nxt      = nd;
    end else begin
      lo3_nxt   = IW'(whole);
      hi3_nxt   = IW'(whole) + IW'(1);
      frac3_nxt = q_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spec1_r <= species;
    grid1_r <= grid_index;
    ld1_r   <= {load_second, load_first};
    d1_r    <= d1_nxt;
    spec2_r <= spec1_r;
    grid2_r <= grid1_r;
    ld2_r   <= ld1_r;
    neg2_r  <= d1_r[RATE_W];
    ph2_r   <= ph2_nxt;
    pl2_r   <= pl2_nxt;
    spec3_r <= spec2_r;
    lo3_r   <= lo3_nxt;
    hi3_r   <= hi3_nxt;
    frac3_r <= frac3_nxt;
    ld3_r   <= ld2_r;
  end

  assign ctl_o     = ctl3_r;
  assign species_o = spec3_r;
  assign lo_idx_o  = lo3_r;
  assign hi_idx_o  = hi3_r;
  assign frac_o    = frac3_r;
  assign wr_pair_o = ld3_r;

endmodule

// ===== hw/rtl/irt_store.sv =====
`timescale 1ns / 1ps
module irt_store #(
  parameter int NUM_SPECIES = irt_pkg::NUM_SPECIES_DEF,
  parameter int NUM_POINTS  = irt_pkg::NUM_POINTS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  irt_pkg::irt_ctl_t                           ctl_i,
  input  logic [irt_pkg::SPEC_W-1:0]                  species_i,
  input  logic [$clog2(NUM_POINTS)-1:0]               lo_idx_i,
  input  logic [$clog2(NUM_POINTS)-1:0]               hi_idx_i,
  input  logic [irt_pkg::FRAC_W-1:0]                  frac_i,
  input  logic [irt_pkg::PAIR_W*irt_pkg::RATE_W-1:0]  wr_pair_i,
  output irt_pkg::irt_ctl_t                           ctl_o,
  output logic [irt_pkg::FRAC_W-1:0]                  frac_o,
  output logic [irt_pkg::PAIR_W*irt_pkg::RATE_W-1:0]  a_pair_o,
  output logic [irt_pkg::PAIR_W*irt_pkg::RATE_W-1:0]  b_pair_o
);
  import irt_pkg::*;

  localparam int DEPTH = NUM_SPECIES * NUM_POINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = PAIR_W * RATE_W;

  logic [PW-1:0]     mem [DEPTH];
  logic [AW-1:0]     base, addr_a, addr_b;
  logic              wr_en;
  irt_ctl_t          ctl_r, ctl_nxt;
  logic [FRAC_W-1:0] frac_r;
  logic [PW-1:0]     a_r, b_r;

  always_comb begin
    base    = ctl_i.spec_ok ? AW'(32'(species_i) * NUM_POINTS) : '0;
    addr_a  = base + AW'(lo_idx_i);
    addr_b  = base + AW'(hi_idx_i);
    wr_en   = ctl_i.vld && !ctl_i.lookup && ctl_i.wr_ok;
    ctl_nxt = ctl_i;
    // loads end here
    ctl_nxt.vld = ctl_i.vld && ctl_i.lookup;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_a] <= wr_pair_i;
    end
    a_r    <= mem[addr_a];
    b_r    <= mem[addr_b];
    frac_r <= frac_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  assign ctl_o    = ctl_r;
  assign frac_o   = frac_r;
  assign a_pair_o = a_r;
  assign b_pair_o = b_r;

endmodule

// ===== hw/rtl/irt_lerp.sv =====
`timescale 1ns / 1ps
module irt_lerp (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  irt_pkg::irt_ctl_t                           ctl_i,
  input  logic [irt_pkg::FRAC_W-1:0]                  frac_i,
  input  logic [irt_pkg::PAIR_W*irt_pkg::RATE_W-1:0]  a_pair_i,
  input  logic [irt_pkg::PAIR_W*irt_pkg::RATE_W-1:0]  b_pair_i,
  output logic                                        vld_o,
  output logic                                        oor_o,
  output logic [irt_pkg::PAIR_W*irt_pkg::RATE_W-1:0]  rates_o
);
  import irt_pkg::*;

  localparam int PW = PAIR_W * RATE_W;

  irt_ctl_t            ctl1_r, ctl2_r;
  logic [FRAC_W-1:0]   frac1_r;
  logic [RATE_W-1:0]   a1_r [PAIR_W];
  logic [RATE_W-1:0]   a2_r [PAIR_W];
  logic [RATE_W:0]     diff1_r [PAIR_W];
  logic [RATE_W:0]     diff1_nxt [PAIR_W];
  logic signed [49:0]  prod2_r [PAIR_W];
  logic signed [49:0]  prod2_nxt [PAIR_W];
  logic [PW-1:0]       rates_r, rates_nxt;
  logic                vld_r, oor_r;

  always_comb begin
    for (int l = 0; l < PAIR_W; l++) begin
      diff1_nxt[l] = {b_pair_i[l*RATE_W+RATE_W-1], b_pair_i[l*RATE_W +: RATE_W]}
                   - {a_pair_i[l*RATE_W+RATE_W-1], a_pair_i[l*RATE_W +: RATE_W]};
      prod2_nxt[l] = $signed(diff1_r[l]) * $signed({1'b0, frac1_r});
      // floor of prod / 2^16, low word only
      rates_nxt[l*RATE_W +: RATE_W] = ctl2_r.spec_ok ?
                                      (a2_r[l] + prod2_r[l][47:16]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    frac1_r <= frac_i;
    for (int l = 0; l < PAIR_W; l++) begin
      a1_r[l]    <= a_pair_i[l*RATE_W +: RATE_W];
      diff1_r[l] <= diff1_nxt[l];
      a2_r[l]    <= a1_r[l];
      prod2_r[l] <= prod2_nxt[l];
    end
    rates_r <= rates_nxt;
    oor_r   <= ctl2_r.oor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      vld_r  <= ctl2_r.vld;
    end
  end

  assign vld_o   = vld_r;
  assign oor_o   = oor_r;
  assign rates_o = rates_r;

endmodule

// ===== hw/rtl/interpolated_rate_table_unit.sv =====
`timescale 1ns / 1ps
// A lookup accepted at a clock edge shows its result on out_* with out_strobe high
// for one cycle, after passing through the pipeline steps listed below.
// Throughput: one load or lookup per cycle while busy is low; no stalls.
// Reset (synchronous, rst_n low): pipeline emptied, configuration back to defaults,
// busy held high; table contents are kept and undefined until loaded.
`include "interpolated_rate_table_unit_macros.svh"
module interpolated_rate_table_unit #(
  parameter int NUM_SPECIES = irt_pkg::NUM_SPECIES_DEF,
  parameter int NUM_POINTS  = irt_pkg::NUM_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_op,
  input  logic        [irt_pkg::SPEC_W-1:0]  in_species,
  input  logic        [irt_pkg::GRID_W-1:0]  in_grid_index,
  input  logic signed [irt_pkg::RATE_W-1:0]  in_load_first,
  input  logic signed [irt_pkg::RATE_W-1:0]  in_load_second,
  input  logic signed [irt_pkg::RATE_W-1:0]  in_x_value,
  // result channel
  output logic                               out_strobe,
  output logic signed [irt_pkg::RATE_W-1:0]  out_first_rate,
  output logic signed [irt_pkg::RATE_W-1:0]  out_second_rate,
  output logic                               out_out_of_range,
  // configuration
  input  logic                               cfg_we,
  input  logic        [irt_pkg::CIDX_W-1:0]  cfg_index,
  input  logic        [irt_pkg::CFG_W-1:0]   cfg_data
);
  import irt_pkg::*;

  localparam int IW = $clog2(NUM_POINTS);
  localparam int PW = PAIR_W * RATE_W;

  // Pipeline map (one register rank per step):
  //   1  register transaction, subtract grid origin (33-bit offset)
  //   2  scale offset by inverse spacing as two 16x32 partial products
  //   3  sum partials, split index/fraction, clamp to grid ends, flag
  //   4  table read of both bracketing points (two read ports), or table write
  //   5  difference of the bracketing rates per lane
  //   6  difference times fraction per lane
  //   7  add floor-scaled step to lower rate, drive result registers
  // Loads write the table in step 4, the same step where lookups read it, so
  // every lookup sees exactly the loads that were accepted before it.

  logic [RATE_W-1:0] x_min_r, x_min_nxt;
  logic [RATE_W-1:0] inv_step_r, inv_step_nxt;
  logic [NDIV_W-1:0] num_div_r, num_div_nxt;
  logic              acc;

  irt_ctl_t          idx_ctl, st_ctl;
  logic [SPEC_W-1:0] idx_species;
  logic [IW-1:0]     idx_lo, idx_hi;
  logic [FRAC_W-1:0] idx_frac, st_frac;
  logic [PW-1:0]     idx_wr_pair, st_a_pair, st_b_pair, rates;
  logic              lerp_vld, lerp_oor;

  // Hold off input while reset is applied; otherwise take one per cycle.
  assign busy = ~rst_n;
  assign acc  = start && !busy;

  // Configuration decode; unknown indexes are dropped.
  always_comb begin
    x_min_nxt    = x_min_r;
    inv_step_nxt = inv_step_r;
    num_div_nxt  = num_div_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_MIN:    x_min_nxt    = cfg_data[RATE_W-1:0];
        CFG_INV_STEP: inv_step_nxt = cfg_data[RATE_W-1:0];
        CFG_NUM_DIV:  num_div_nxt  = cfg_data[NDIV_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= X_MIN_RST;
      inv_step_r <= INV_STEP_RST;
      num_div_r  <= NUM_DIV_RST;
    end else begin
      x_min_r    <= x_min_nxt;
      inv_step_r <= inv_step_nxt;
      num_div_r  <= num_div_nxt;
    end
  end

  // Steps 1 to 3: grid index, fraction and range flag.
  irt_index #(
    .NUM_SPECIES (NUM_SPECIES),
    .NUM_POINTS  (NUM_POINTS)
  ) u_index (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .op          (in_op),
    .species     (in_species),
    .grid_index  (in_grid_index),
    .load_first  (in_load_first),
    .load_second (in_load_second),
    .x_value     (in_x_value),
    .x_min       (x_min_r),
    .inv_step    (inv_step_r),
    .num_div     (num_div_r),
    .ctl_o       (idx_ctl),
    .species_o   (idx_species),
    .lo_idx_o    (idx_lo),
    .hi_idx_o    (idx_hi),
    .frac_o      (idx_frac),
    .wr_pair_o   (idx_wr_pair)
  );

  // Step 4: table of rate pairs.
  irt_store #(
    .NUM_SPECIES (NUM_SPECIES),
    .NUM_POINTS  (NUM_POINTS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (idx_ctl),
    .species_i (idx_species),
    .lo_idx_i  (idx_lo),
    .hi_idx_i  (idx_hi),
    .frac_i    (idx_frac),
    .wr_pair_i (idx_wr_pair),
    .ctl_o     (st_ctl),
    .frac_o    (st_frac),
    .a_pair_o  (st_a_pair),
    .b_pair_o  (st_b_pair)
  );

  // Steps 5 to 7: interpolate both rates side by side.
  irt_lerp u_lerp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (st_ctl),
    .frac_i   (st_frac),
    .a_pair_i (st_a_pair),
    .b_pair_i (st_b_pair),
    .vld_o    (lerp_vld),
    .oor_o    (lerp_oor),
    .rates_o  (rates)
  );

  // Lane 0 carries the first rate, lane 1 the second.
  assign out_strobe       = lerp_vld;
  assign out_first_rate   = rates[RATE_W-1:0];
  assign out_second_rate  = rates[2*RATE_W-1:RATE_W];
  assign out_out_of_range = lerp_oor;

  // Every result traces back to a lookup accepted a fixed time earlier.
  `IRT_ASSERT_IMPLY(a_strobe_from_lookup, clk, rst_n, out_strobe,
                    $past(acc && (in_op == OP_LOOKUP), LATENCY))
  // Every accepted lookup yields exactly one result at the fixed latency.
  `IRT_ASSERT_DELAY(a_lookup_gives_result, clk, rst_n, acc && (in_op == OP_LOOKUP),
                    LATENCY, out_strobe)
  // A lookup on a missing species returns zero rates, flagged.
  `IRT_ASSERT_DELAY(a_bad_species_zero, clk, rst_n,
                    acc && (in_op == OP_LOOKUP) && (32'(in_species) >= NUM_SPECIES),
                    LATENCY,
                    out_strobe && out_out_of_range && (out_first_rate == '0) &&
                    (out_second_rate == '0))

endmodule

// ===== test/tb_interpolated_rate_table_unit.sv =====
`timescale 1ns / 1ps
module tb_interpolated_rate_table_unit;
  import irt_pkg::*;

  // Allow this many cycles for outstanding results to drain before calling them lost.
  localparam int DRAIN_LIMIT = 1000;
  localparam longint X_HI = 64'sd2147483647;
  localparam longint X_LO = -64'sd2147483648;

  // One transaction on the input channel.
  typedef struct packed {
    logic                     op;
    logic [SPEC_W-1:0]        species;
    logic [GRID_W-1:0]        grid;
    logic signed [RATE_W-1:0] load_first;
    logic signed [RATE_W-1:0] load_second;
    logic signed [RATE_W-1:0] x;
  } txn_t;

  // One lookup result.
  typedef struct packed {
    logic signed [RATE_W-1:0] first_rate;
    logic signed [RATE_W-1:0] second_rate;
    logic                     flagged;
  } rate_res_t;

  // Directed stimulus row; rows marked typed carry a hand-written expectation.
  typedef struct packed {
    txn_t      item;
    bit        typed;
    rate_res_t want;
  } dir_row_t;

  // One setting of the three configuration registers.
  typedef struct packed {
    logic signed [RATE_W-1:0] origin;
    logic [RATE_W-1:0]        inv_step;
    logic [NDIV_W-1:0]        divisions;
  } grid_cfg_t;

  localparam rate_res_t NO_RES = '0;
  localparam int NUM_DIRECTED = 21;
  localparam int NUM_PHASES = 6;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_op;
  logic [SPEC_W-1:0]        in_species;
  logic [GRID_W-1:0]        in_grid_index;
  logic signed [RATE_W-1:0] in_load_first;
  logic signed [RATE_W-1:0] in_load_second;
  logic signed [RATE_W-1:0] in_x_value;
  logic                     out_strobe;
  logic signed [RATE_W-1:0] out_first_rate;
  logic signed [RATE_W-1:0] out_second_rate;
  logic                     out_out_of_range;
  logic                     cfg_we;
  logic [CIDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  interpolated_rate_table_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_species       (in_species),
    .in_grid_index    (in_grid_index),
    .in_load_first    (in_load_first),
    .in_load_second   (in_load_second),
    .in_x_value       (in_x_value),
    .out_strobe       (out_strobe),
    .out_first_rate   (out_first_rate),
    .out_second_rate  (out_second_rate),
    .out_out_of_range (out_out_of_range),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Shadow copy of the grid tables and of the register file.
  logic signed [RATE_W-1:0] grid_first  [NUM_SPECIES_DEF][NUM_POINTS_DEF];
  logic signed [RATE_W-1:0] grid_second [NUM_SPECIES_DEF][NUM_POINTS_DEF];
  bit                       point_loaded[NUM_SPECIES_DEF][NUM_POINTS_DEF];
  logic signed [RATE_W-1:0] cur_origin    = X_MIN_RST;
  logic [RATE_W-1:0]        cur_inv_step  = INV_STEP_RST;
  logic [NDIV_W-1:0]        cur_divisions = NUM_DIV_RST;

  // Interpolated results still owed by the block, oldest first.
  rate_res_t pending_rates[$];

  int  fail_count     = 0;
  int  loads_sent     = 0;
  int  lookups_sent   = 0;
  int  results_seen   = 0;
  int  clamped_seen   = 0;
  bit  burst_mode     = 1'b0;

  dir_row_t  directed_rows [NUM_DIRECTED];
  grid_cfg_t phase_cfg [NUM_PHASES] = '{
    '{32'sh0000_0000, 32'h0001_0000, 10'd1023},  // unit spacing, full grid
    '{32'sh8000_0000, 32'hFFFF_FFFF, 10'd0},     // lowest origin, densest grid, zero divisions
    '{32'sh7FFF_FFFF, 32'h0000_0000, 10'd1},     // highest origin, zero inverse step
    '{32'shFFFB_0000, 32'h0004_0000, 10'd16},    // quarter spacing from -5.0
    '{32'sh0001_0000, 32'h0000_8000, 10'd1023},  // spacing 2.0, full grid
    '{32'sh0000_0000, 32'h0001_0000, 10'd8}      // replaced by a random setting
  };
  int phase_items [NUM_PHASES] = '{150, 130, 110, 140, 140, 130};

  rate_res_t seen;
  rate_res_t head;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count a failure; print only the first few.
  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // Map a coordinate to the bracketing grid points and the 0.16 weight.
  function automatic void locate(input logic signed [RATE_W-1:0] x,
                                 output int unsigned lo, output int unsigned hi,
                                 output logic [FRAC_W-1:0] frac, output logic clamped);
    longint            d;
    longint unsigned   ud;
    longint unsigned   q;
    longint unsigned   whole;
    int unsigned       nd;
    nd = cur_divisions;
    if (nd < 1) nd = 1;
    if (nd > NUM_POINTS_DEF - 1) nd = NUM_POINTS_DEF - 1;
    d = longint'(x) - longint'(cur_origin);
    if (d < 0) begin
      // below the grid: pin to point 0
      lo = 0;
      hi = 0;
      frac = '0;
      clamped = 1'b1;
    end else begin
      ud = d;
      q = (ud >> 16) * cur_inv_step + (((ud & 64'hFFFF) * cur_inv_step) >> 16);
      whole = q >> 16;
      frac = q[FRAC_W-1:0];
      if (whole >= nd) begin
        // past the last interval; a dead-on hit of the last point is not a clamp
        clamped = (whole > nd) || (frac != 0);
        lo = nd;
        hi = nd;
        frac = '0;
      end else begin
        lo = 32'(whole);
        hi = 32'(whole + 1);
        clamped = 1'b0;
      end
    end
  endfunction

  // a + floor((b - a) * w / 2^16), truncated to the rate width.
  function automatic logic [RATE_W-1:0] blend(input logic signed [RATE_W-1:0] a,
                                              input logic signed [RATE_W-1:0] b,
                                              input logic [FRAC_W-1:0] w);
    longint weight;
    longint delta;
    weight = w;
    delta = (longint'(b) - longint'(a)) * weight;
    return 32'(longint'(a) + (delta >>> 16));
  endfunction

  // Apply one accepted transaction to the shadow table; return 1 with the
  // expected result for a lookup. Every species and grid index the ports can
  // carry is valid at the default sizes.
  function automatic bit predict(input txn_t t, output rate_res_t r);
    int unsigned       lo;
    int unsigned       hi;
    logic [FRAC_W-1:0] w;
    logic              clamped;
    r = '0;
    if (t.op == OP_LOAD) begin
      grid_first[t.species][t.grid]   = t.load_first;
      grid_second[t.species][t.grid]  = t.load_second;
      point_loaded[t.species][t.grid] = 1'b1;
      loads_sent++;
      return 1'b0;
    end
    locate(t.x, lo, hi, w, clamped);
    r.first_rate  = blend(grid_first[t.species][lo], grid_first[t.species][hi], w);
    r.second_rate = blend(grid_second[t.species][lo], grid_second[t.species][hi], w);
    r.flagged     = clamped;
    lookups_sent++;
    return 1'b1;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones; none in burst stretches.
  function automatic int pick_gap();
    int roll;
    if (burst_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;  // small, around zero
      default: return $urandom;
    endcase
  endfunction

  function automatic txn_t load_txn(input logic [SPEC_W-1:0] sp, input logic [GRID_W-1:0] g);
    txn_t t;
    t.op          = OP_LOAD;
    t.species     = sp;
    t.grid        = g;
    t.load_first  = pick_rate();
    t.load_second = pick_rate();
    t.x           = $urandom;
    return t;
  endfunction

  // Pick a lookup coordinate: mostly inside the grid, some on grid points,
  // some below the origin, the rest anywhere.
  function automatic logic signed [RATE_W-1:0] pick_coord();
    longint unsigned spacing;
    longint unsigned reach;
    longint unsigned off;
    longint          xv;
    int unsigned     nd;
    int              mode;
    nd = (cur_divisions == 0) ? 1 : cur_divisions;
    spacing = (cur_inv_step == 0) ? 64'h1_0000_0000 : (64'h1_0000_0000 / cur_inv_step);
    reach = spacing * (nd + 1);
    mode = $urandom_range(0, 99);
    if (mode < 60) off = {$urandom, $urandom} % (reach + 1);
    else if (mode < 75) off = spacing * $urandom_range(0, nd + 1);
    else if (mode < 85) off = 0;
    else return $urandom;
    xv = longint'(cur_origin) + longint'(off);
    if (mode >= 75) xv = longint'(cur_origin) - longint'($urandom_range(1, 32'h00FF_FFFF));
    if (xv > X_HI) xv = X_HI;
    if (xv < X_LO) xv = X_LO;
    return 32'(xv);
  endfunction

  // Present one transaction, hold it until accepted, then record what it owes.
  task automatic send_txn(input txn_t t, input bit typed, input rate_res_t want);
    rate_res_t r;
    int        gap;
    in_op          <= t.op;
    in_species     <= t.species;
    in_grid_index  <= t.grid;
    in_load_first  <= t.load_first;
    in_load_second <= t.load_second;
    in_x_value     <= t.x;
    start          <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (predict(t, r)) pending_rates.push_back(typed ? want : r);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for all owed results, then let in-flight loads finish writing.
  task automatic settle();
    int waited = 0;
    while (pending_rates.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_rates.size() != 0) begin
      flag_failure($sformatf("%0d expected results never arrived", pending_rates.size()));
      pending_rates.delete();
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Write all three registers back to back; the block must be idle.
  task automatic write_settings(input grid_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_X_MIN;
    cfg_data  <= c.origin;
    @(posedge clk);
    cur_origin = c.origin;
    cfg_index <= CFG_INV_STEP;
    cfg_data  <= c.inv_step;
    @(posedge clk);
    cur_inv_step = c.inv_step;
    cfg_index <= CFG_NUM_DIV;
    cfg_data  <= CFG_W'(c.divisions);
    @(posedge clk);
    cur_divisions = c.divisions;
    cfg_we <= 1'b0;
  endtask

  // Random traffic under the current setting. Before each lookup, load any
  // bracketing point not yet written so no undefined entry is ever read.
  task automatic run_random(input int n);
    txn_t              t;
    int unsigned       lo;
    int unsigned       hi;
    logic [FRAC_W-1:0] w;
    logic              clamped;
    logic [GRID_W-1:0] g;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (i == n / 2) begin
        // hold off the sender until the pipeline has delivered everything
        start <= 1'b0;
        do @(posedge clk); while (pending_rates.size() != 0);
      end
      if ($urandom_range(0, 99) < 35) begin
        g = GRID_W'($urandom_range(0, NUM_POINTS_DEF - 1));
        if ($urandom_range(0, 1) == 1) g = GRID_W'(g % (cur_divisions + 2));
        send_txn(load_txn(SPEC_W'($urandom), g), 1'b0, NO_RES);
      end else begin
        t = load_txn(SPEC_W'($urandom), GRID_W'($urandom));
        t.op = OP_LOOKUP;
        t.x  = pick_coord();
        locate(t.x, lo, hi, w, clamped);
        if (!point_loaded[t.species][lo])
          send_txn(load_txn(t.species, GRID_W'(lo)), 1'b0, NO_RES);
        if (!point_loaded[t.species][hi])
          send_txn(load_txn(t.species, GRID_W'(hi)), 1'b0, NO_RES);
        send_txn(t, 1'b0, NO_RES);
      end
    end
    burst_mode = 1'b0;
  endtask

  // Check every strobed result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) begin
      seen = '{out_first_rate, out_second_rate, out_out_of_range};
      if (pending_rates.size() == 0) begin
        flag_failure($sformatf("unexpected result %h %h %b",
                               seen.first_rate, seen.second_rate, seen.flagged));
      end else begin
        head = pending_rates.pop_front();
        results_seen++;
        if (head.flagged) clamped_seen++;
        if (seen.first_rate !== head.first_rate || seen.second_rate !== head.second_rate ||
            seen.flagged !== head.flagged)
          flag_failure($sformatf("result %0d: expected %h %h %b, got %h %h %b",
                                 results_seen, head.first_rate, head.second_rate,
                                 head.flagged, seen.first_rate, seen.second_rate,
                                 seen.flagged));
      end
    end
  end

  // Stop a hung run.
  initial begin
    #5_000_000;
    $display("tb_interpolated_rate_table_unit failed");
    $finish;
  end

  initial begin
    // Directed part under the reset setting: unit spacing from 0, 1023 divisions.
    directed_rows = '{
      // load the extremes at point 0, swapped at point 1, zeros at 2, and the last point
      '{'{OP_LOAD, 2'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0}, 1'b0, NO_RES},
      '{'{OP_LOAD, 2'd0, 10'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0}, 1'b0, NO_RES},
      '{'{OP_LOAD, 2'd0, 10'd2, 32'h0000_0000, 32'h0000_0000, 32'h0}, 1'b0, NO_RES},
      '{'{OP_LOAD, 2'd0, 10'd1023, 32'h1234_5678, 32'hFEDC_BA98, 32'h0}, 1'b0, NO_RES},
      // highest species: 3.0/-3.0 at 1022, 5.0/-5.0 at 1023, 1.0/-1.0 at 0,
      // 2.0/-2.0 at 1
      '{'{OP_LOAD, 2'd3, 10'd1022, 32'h0003_0000, 32'hFFFD_0000, 32'h0}, 1'b0, NO_RES},
      '{'{OP_LOAD, 2'd3, 10'd1023, 32'h0005_0000, 32'hFFFB_0000, 32'h0}, 1'b0, NO_RES},
      '{'{OP_LOAD, 2'd3, 10'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0}, 1'b0, NO_RES},
      '{'{OP_LOAD, 2'd3, 10'd1, 32'h0002_0000, 32'hFFFE_0000, 32'h0}, 1'b0, NO_RES},
      // on point 0, then below the grid
      '{'{OP_LOOKUP, 2'd0, 10'd0, 32'h0, 32'h0, 32'h0000_0000}, 1'b1,
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}},
      '{'{OP_LOOKUP, 2'd0, 10'd0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1,
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1}},
      '{'{OP_LOOKUP, 2'd0, 10'd0, 32'h0, 32'h0, 32'h8000_0000}, 1'b1,
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1}},
      // half and nearly full weight across the widest possible swing, then on point 1
      '{'{OP_LOOKUP, 2'd0, 10'd0, 32'h0, 32'h0, 32'h0000_8000}, 1'b0, NO_RES},
      '{'{OP_LOOKUP, 2'd0, 10'd0, 32'h0, 32'h0, 32'h0000_FFFF}, 1'b0, NO_RES},
      '{'{OP_LOOKUP, 2'd0, 10'd0, 32'h0, 32'h0, 32'h0001_0000}, 1'b1,
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0}},
      // exactly on the last point, just past it, and the top coordinate
      '{'{OP_LOOKUP, 2'd0, 10'd0, 32'h0, 32'h0, 32'h03FF_0000}, 1'b1,
        '{32'h1234_5678, 32'hFEDC_BA98, 1'b0}},
      '{'{OP_LOOKUP, 2'd0, 10'd0, 32'h0, 32'h0, 32'h03FF_0001}, 1'b1,
        '{32'h1234_5678, 32'hFEDC_BA98, 1'b1}},
      '{'{OP_LOOKUP, 2'd0, 10'd0, 32'h0, 32'h0, 32'h7FFF_FFFF}, 1'b1,
        '{32'h1234_5678, 32'hFEDC_BA98, 1'b1}},
      // halfway along the last interval: 4.0 and -4.0; then on point 0: 1.0 and -1.0
      '{'{OP_LOOKUP, 2'd3, 10'd0, 32'h0, 32'h0, 32'h03FE_8000}, 1'b1,
        '{32'h0004_0000, 32'hFFFC_0000, 1'b0}},
      '{'{OP_LOOKUP, 2'd3, 10'd0, 32'h0, 32'h0, 32'h0000_0000}, 1'b1,
        '{32'h0001_0000, 32'hFFFF_0000, 1'b0}},
      // overwrite a point and read it on the very next transaction
      '{'{OP_LOAD, 2'd0, 10'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0}, 1'b0, NO_RES},
      '{'{OP_LOOKUP, 2'd0, 10'd0, 32'h0, 32'h0, 32'h0000_0000}, 1'b1,
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0}}
    };

    // Drive every input to a known value and hold reset.
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_op          <= OP_LOAD;
    in_species     <= '0;
    in_grid_index  <= '0;
    in_load_first  <= '0;
    in_load_second <= '0;
    in_x_value     <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_X_MIN;
    cfg_data       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);

    for (int r = 0; r < NUM_DIRECTED; r++)
      send_txn(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

    // Last setting is random: any origin, moderate spacing, a short grid.
    phase_cfg[NUM_PHASES-1].origin    = $urandom;
    phase_cfg[NUM_PHASES-1].inv_step  = $urandom_range(32'h0000_1000, 32'h0010_0000);
    phase_cfg[NUM_PHASES-1].divisions = NDIV_W'($urandom_range(2, 64));

    for (int p = 0; p < NUM_PHASES; p++) begin
      // drain before touching the registers
      start <= 1'b0;
      settle();
      write_settings(phase_cfg[p]);
      run_random(phase_items[p]);
    end

    start <= 1'b0;
    settle();

    $display("Covered %0d loads and %0d lookups over %0d register settings;",
             loads_sent, lookups_sent, NUM_PHASES + 1);
    $display("%0d results checked, %0d of them clamped to a grid end.",
             results_seen, clamped_seen);
    if (fail_count == 0) begin
      $display("tb_interpolated_rate_table_unit passed");
    end else begin
      $display("tb_interpolated_rate_table_unit failed");
    end
    $finish;
  end

endmodule

// ===== interpolated_rate_table_unit.f =====
+incdir+hw/rtl
hw/rtl/irt_pkg.sv
hw/rtl/irt_index.sv
hw/rtl/irt_store.sv
hw/rtl/irt_lerp.sv
hw/rtl/interpolated_rate_table_unit.sv
test/tb_interpolated_rate_table_unit.sv
